// ----- design/aes_pkg.sv -----
package aes_pkg;

	localparam int ROUND_COUNT     = 10;
	localparam int ROUND_KEY_WORDS = 44;
	localparam int ROUND_W         = $clog2(ROUND_COUNT + 1);
	localparam int CFG_IDX_W       = 2;
	localparam int HALF_W          = 64;
	localparam int BLOCK_W         = 128;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Command from the sequencer to the round datapath.
	typedef struct packed {
		logic               load;
		logic               round_en;
		logic               final_round;
		logic [ROUND_W-1:0] round;
	} ctrl_cmd_t;

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] v;
		case (r)
			ROUND_W'(1):  v = 8'h01;
			ROUND_W'(2):  v = 8'h02;
			ROUND_W'(3):  v = 8'h04;
			ROUND_W'(4):  v = 8'h08;
			ROUND_W'(5):  v = 8'h10;
			ROUND_W'(6):  v = 8'h20;
			ROUND_W'(7):  v = 8'h40;
			ROUND_W'(8):  v = 8'h80;
			ROUND_W'(9):  v = 8'h1b;
			ROUND_W'(10): v = 8'h36;
			default:      v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] gf_dbl(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [31:0] mix_column(input logic [31:0] col);
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		a0 = col[31:24];
		a1 = col[23:16];
		a2 = col[15:8];
		a3 = col[7:0];
		d0 = gf_dbl(a0);
		d1 = gf_dbl(a1);
		d2 = gf_dbl(a2);
		d3 = gf_dbl(a3);
		return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
			a0 ^ d1 ^ d2 ^ a2 ^ a3,
			a0 ^ a1 ^ d2 ^ d3 ^ a3,
			d0 ^ a0 ^ a1 ^ a2 ^ d3};
	endfunction

	// One step of the key schedule: the four words of round key r from those of r-1.
	function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] rk,
			input logic [ROUND_W-1:0] r);
		logic [31:0] t, n0, n1, n2, n3;
		t  = sbox_word({rk[23:0], rk[31:24]}) ^ {rcon(r), 24'h0};
		n0 = rk[127:96] ^ t;
		n1 = rk[95:64] ^ n0;
		n2 = rk[63:32] ^ n1;
		n3 = rk[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

// ----- design/aes128_block_encrypt_core.sv -----
// AES-128 block encryption core.
//
// Key setup: the 128-bit key is written over the configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data). Index 0 carries key bytes 0 to 7,
// index 1 carries bytes 8 to 15; other indexes are ignored. Writes are taken
// only while the core is idle and start is low. The round keys are derived on
// the fly from the stored key during each block, so a new key is usable right
// after its write.
//
// A request is accepted on a clock edge with start high and busy low. The
// plaintext halves are sampled at that edge. The core then runs ten rounds,
// one per cycle, on a single shared round unit next to one key schedule step.
// The ciphertext appears on cipher_high/cipher_low with done high for exactly
// one cycle once the last round is registered, and busy drops in that same
// cycle, so a new request can be accepted at the edge that ends it; a block is
// taken only once the one before is through, bounded by the single round unit. The
// receiver cannot stall; done is a one-cycle strobe and must be captured.
// Reset (arst_n low) returns the sequencer to idle and drops a block in flight.
// After reset busy stays high while both key registers are cleared to zero.
module aes128_block_encrypt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [aes_pkg::HALF_W-1:0]    plain_high,
	input  logic [aes_pkg::HALF_W-1:0]    plain_low,
	output logic                          done,
	output logic [aes_pkg::HALF_W-1:0]    cipher_high,
	output logic [aes_pkg::HALF_W-1:0]    cipher_low,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aes_pkg::HALF_W-1:0]    cfg_data
);
	import aes_pkg::*;

	ctrl_cmd_t            cmd;
	logic                 cfg_we;
	logic                 ctrl_busy;
	logic [1:0]           key_init_q;
	logic                 key_init;
	logic                 key_we;
	logic [CFG_IDX_W-1:0] key_index;
	logic [HALF_W-1:0]    key_data;

	// After reset a short sweep writes zero into both key registers, so the
	// key storage itself needs no reset. The sweep clears the high half first
	// and then the low half, and the core reports busy during it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_init_q <= 2'b11;
		end else begin
			key_init_q <= {1'b0, key_init_q[1]};
		end
	end

	assign key_init = key_init_q[0];
	assign busy     = ctrl_busy || key_init;

	// Configuration is accepted only while the core is idle, the key is set up
	// and no request is being offered, so a write never meets a block.
	assign cfg_ready = !busy && !start;
	assign cfg_we    = cfg_valid && cfg_ready;

	aes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !key_init),
		.busy   (ctrl_busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The clear sweep reuses the configuration write port of the datapath,
	// writing zero to one key index per cycle.
	assign key_we    = cfg_we || key_init;
	assign key_index = key_init ? (key_init_q[1] ? CFG_KEY_HIGH : CFG_KEY_LOW) : cfg_index;
	assign key_data  = key_init ? '0 : cfg_data;

	aes_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.cfg_we      (key_we),
		.cfg_index   (key_index),
		.cfg_data    (key_data),
		.plain_high  (plain_high),
		.plain_low   (plain_low),
		.cipher_high (cipher_high),
		.cipher_low  (cipher_low)
	);

endmodule

// ----- design/aes_ctrl.sv -----
module aes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output aes_pkg::ctrl_cmd_t cmd
);
	import aes_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t             state_q;
	logic [ROUND_W-1:0] round_q;
	logic               done_q;
	logic               last_round;

	assign last_round = (round_q == ROUND_W'(ROUND_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						round_q <= ROUND_W'(1);
					end
				end
				ST_RUN: begin
					if (last_round) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						round_q <= round_q + ROUND_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy            = (state_q == ST_RUN);
	assign done            = done_q;
	assign cmd.load        = start && (state_q == ST_IDLE);
	assign cmd.round_en    = (state_q == ST_RUN);
	assign cmd.final_round = last_round;
	assign cmd.round       = round_q;

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && (round_q == ROUND_W'(1)))
		else $error("accepted request did not start round one");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (round_q != '0) && (round_q <= ROUND_W'(ROUND_COUNT)))
		else $error("round counter out of range");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy && last_round |=> done && !busy)
		else $error("no result after the last round");

	a_done_only_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && $past(last_round))
		else $error("result strobe without a finished block");

endmodule

// ----- design/aes_datapath.sv -----
module aes_datapath (
	input  logic                             clk,
	input  aes_pkg::ctrl_cmd_t               cmd,
	input  logic                             cfg_we,
	input  logic [aes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aes_pkg::HALF_W-1:0]       cfg_data,
	input  logic [aes_pkg::HALF_W-1:0]       plain_high,
	input  logic [aes_pkg::HALF_W-1:0]       plain_low,
	output logic [aes_pkg::HALF_W-1:0]       cipher_high,
	output logic [aes_pkg::HALF_W-1:0]       cipher_low
);
	import aes_pkg::*;

	logic [HALF_W-1:0]  key_high_q;
	logic [HALF_W-1:0]  key_low_q;
	logic [BLOCK_W-1:0] state_q;
	logic [BLOCK_W-1:0] rk_q;
	logic [BLOCK_W-1:0] rk_next;
	logic [BLOCK_W-1:0] shifted;
	logic [BLOCK_W-1:0] mixed;
	logic [BLOCK_W-1:0] round_out;

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Byte n of the state sits at bits [127-8n -: 8]; column c holds bytes 4c..4c+3.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int q = 0; q < 4; q++) begin
				shifted[BLOCK_W-1-8*(c*4+q) -: 8] =
					SBOX[state_q[BLOCK_W-1-8*(((c+q)%4)*4+q) -: 8]];
			end
			mixed[BLOCK_W-1-32*c -: 32] = mix_column(shifted[BLOCK_W-1-32*c -: 32]);
		end
	end

	assign rk_next   = next_round_key(rk_q, cmd.round);
	assign round_out = (cmd.final_round ? shifted : mixed) ^ rk_next;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			rk_q    <= {key_high_q, key_low_q};
		end else if (cmd.round_en) begin
			state_q <= round_out;
			rk_q    <= rk_next;
		end
	end

	assign cipher_high = state_q[BLOCK_W-1:HALF_W];
	assign cipher_low  = state_q[HALF_W-1:0];

endmodule
